// ===== rtl/core/ofvs_pkg.sv =====
// ----------------------------------------------------------------------------
// ofvs_pkg
// Shared widths, register indexes and stage payload types for the
// optical-flow velocity solver.
// ----------------------------------------------------------------------------
package ofvs_pkg;

	localparam int FIELD_W = 32;           // tensor sum field width
	localparam int MAG_W   = 32;           // magnitude of a field
	localparam int PROD_W  = 64;           // product / sum magnitude
	localparam int VEL_W   = 16;           // Q3.12 velocity
	localparam int CLAMP_W = 15;
	localparam int THR_W   = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 32;
	localparam int QBITS   = 16;           // 3 integer + 13 fraction bits
	localparam int INT_BITS = 3;
	localparam int DIV_W   = PROD_W + INT_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_DET_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT   = 1'b1;

	localparam logic [THR_W-1:0]   THR_RESET   = 32'd7;
	localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd24576;

	// determinant and numerators in sign-magnitude form
	typedef struct packed {
		logic [PROD_W-1:0] det;
		logic [PROD_W-1:0] numx;
		logic [PROD_W-1:0] numy;
		logic              det_neg;
		logic              numx_neg;
		logic              numy_neg;
	} sums_t;

	// side info that rides along with each quotient
	typedef struct packed {
		logic neg;
		logic sat;
	} div_tag_t;

endpackage

// ===== rtl/core/ofvs_front.sv =====
// ----------------------------------------------------------------------------
// ofvs_front
// Magnitudes, the six tensor products and the signed sums that give the
// determinant and both Cramer numerators. Three register stages.
// ----------------------------------------------------------------------------
module ofvs_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [ofvs_pkg::FIELD_W-1:0] sum_xx,
	input  logic signed [ofvs_pkg::FIELD_W-1:0] sum_yy,
	input  logic signed [ofvs_pkg::FIELD_W-1:0] sum_xy,
	input  logic signed [ofvs_pkg::FIELD_W-1:0] sum_xt,
	input  logic signed [ofvs_pkg::FIELD_W-1:0] sum_yt,
	output logic                               valid_s3,
	output ofvs_pkg::sums_t                    sums_s3
);
	import ofvs_pkg::*;

	// two's complement field to magnitude
	function automatic logic [MAG_W-1:0] fmag(input logic [FIELD_W-1:0] v);
		return v[FIELD_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
	endfunction

	// signed-magnitude add, result {neg, mag}; zero is never negative
	function automatic logic [PROD_W:0] sm_add(input logic [PROD_W-1:0] ma,
		input logic na, input logic [PROD_W-1:0] mb, input logic nb);
		logic [PROD_W-1:0] m;
		logic              n;
		if (na == nb) begin
			m = ma + mb;
			n = na;
		end else if (ma >= mb) begin
			m = ma - mb;
			n = na;
		end else begin
			m = mb - ma;
			n = nb;
		end
		if (m == '0) n = 1'b0;
		return {n, m};
	endfunction

	logic             valid_s1, valid_s2;
	logic [MAG_W-1:0] axx_s1, ayy_s1, axy_s1, axt_s1, ayt_s1;
	logic             sxx_s1, syy_s1, sxy_s1, sxt_s1, syt_s1;
	logic [PROD_W-1:0] p_xxyy_s2, p_xyxy_s2, p_ytxy_s2, p_xtyy_s2, p_xtxy_s2, p_ytxx_s2;
	logic             n_xxyy_s2, n_ytxy_s2, n_xtyy_s2, n_xtxy_s2, n_ytxx_s2;
	logic [PROD_W:0]  det_sm, numx_sm, numy_sm;

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: sign and magnitude of each field
	always_ff @(posedge clk) begin
		axx_s1 <= fmag(sum_xx);
		ayy_s1 <= fmag(sum_yy);
		axy_s1 <= fmag(sum_xy);
		axt_s1 <= fmag(sum_xt);
		ayt_s1 <= fmag(sum_yt);
		sxx_s1 <= sum_xx[FIELD_W-1];
		syy_s1 <= sum_yy[FIELD_W-1];
		sxy_s1 <= sum_xy[FIELD_W-1];
		sxt_s1 <= sum_xt[FIELD_W-1];
		syt_s1 <= sum_yt[FIELD_W-1];
	end

	// stage 2: products, with the sign each term enters its sum with
	always_ff @(posedge clk) begin
		p_xxyy_s2 <= axx_s1 * ayy_s1;
		p_xyxy_s2 <= axy_s1 * axy_s1;
		p_ytxy_s2 <= ayt_s1 * axy_s1;
		p_xtyy_s2 <= axt_s1 * ayy_s1;
		p_xtxy_s2 <= axt_s1 * axy_s1;
		p_ytxx_s2 <= ayt_s1 * axx_s1;
		n_xxyy_s2 <= sxx_s1 ^ syy_s1;
		n_ytxy_s2 <= syt_s1 ^ sxy_s1;
		n_xtyy_s2 <= ~(sxt_s1 ^ syy_s1);
		n_xtxy_s2 <= sxt_s1 ^ sxy_s1;
		n_ytxx_s2 <= ~(syt_s1 ^ sxx_s1);
	end

	// stage 3: det = xx*yy - xy*xy, numx = yt*xy - xt*yy, numy = xt*xy - yt*xx
	always_comb begin
		det_sm  = sm_add(p_xxyy_s2, n_xxyy_s2, p_xyxy_s2, 1'b1);
		numx_sm = sm_add(p_ytxy_s2, n_ytxy_s2, p_xtyy_s2, n_xtyy_s2);
		numy_sm = sm_add(p_xtxy_s2, n_xtxy_s2, p_ytxx_s2, n_ytxx_s2);
	end

	always_ff @(posedge clk) begin
		sums_s3.det      <= det_sm[PROD_W-1:0];
		sums_s3.det_neg  <= det_sm[PROD_W];
		sums_s3.numx     <= numx_sm[PROD_W-1:0];
		sums_s3.numx_neg <= numx_sm[PROD_W];
		sums_s3.numy     <= numy_sm[PROD_W-1:0];
		sums_s3.numy_neg <= numy_sm[PROD_W];
	end

endmodule

// ===== rtl/core/ofvs_divider.sv =====
// ----------------------------------------------------------------------------
// ofvs_divider
// Pipelined restoring divider: floor(num * 2^13 / den) over 16 stages,
// one quotient bit per stage. Valid only when num < 8 * den.
// ----------------------------------------------------------------------------
module ofvs_divider (
	input  logic                           clk,
	input  logic [ofvs_pkg::PROD_W-1:0]    num,
	input  logic [ofvs_pkg::PROD_W-1:0]    den,
	input  ofvs_pkg::div_tag_t             tag_in,
	output logic [ofvs_pkg::QBITS-1:0]     quo,
	output ofvs_pkg::div_tag_t             tag_out
);
	import ofvs_pkg::*;

	logic [DIV_W-1:0] rem_s [QBITS+1];
	logic [DIV_W-1:0] dv_s  [QBITS+1];
	logic [QBITS-1:0] q_s   [QBITS+1];
	div_tag_t         tag_s [QBITS+1];

	// stage 0 is the input; divisor scaled by 8 so the quotient is fractional
	always_comb begin
		rem_s[0] = {{INT_BITS{1'b0}}, num};
		dv_s[0]  = {den, {INT_BITS{1'b0}}};
		q_s[0]   = '0;
		tag_s[0] = tag_in;
	end

	// one shift, compare and subtract per stage
	for (genvar i = 0; i < QBITS; i++) begin : g_step
		logic [DIV_W:0] r2;
		logic           ge;
		always_comb begin
			r2 = {rem_s[i], 1'b0};
			ge = r2 >= {1'b0, dv_s[i]};
		end
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? DIV_W'(r2 - {1'b0, dv_s[i]}) : DIV_W'(r2);
			dv_s[i+1]  <= dv_s[i];
			q_s[i+1]   <= {q_s[i][QBITS-2:0], ge};
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign quo     = q_s[QBITS];
	assign tag_out = tag_s[QBITS];

endmodule

// ===== rtl/core/optical_flow_velocity_solve.sv =====
// ----------------------------------------------------------------------------
// optical_flow_velocity_solve
// Lucas-Kanade 2x2 velocity solve, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the five tensor sums of a pixel (Q.8, signed); the item
//   is taken on any edge where start is high, busy is always low, so a new
//   pixel may enter every cycle.
//   When a result is ready, done pulses for one cycle with vel_x, vel_y
//   (Q3.12) and solved. Results leave in input order; the receiver cannot
//   hold them off, so nothing waits at the output.
//   The pipeline has 3 front stages (magnitude, multiply, sum),
//   1 threshold/setup stage, 16 divider stages (one quotient bit each, the
//   pipelined restoring divider sets the depth) and 1 rounding stage.
//   Throughput is one item per cycle.
//   Registers: cfg_idx 0 is det_threshold, 1 is clamp_limit; write them only
//   while no item is in flight.
//   Reset clears all valid bits and restores det_threshold = 7 and
//   clamp_limit = 24576 (6.0). Items in flight at reset are dropped.
// ----------------------------------------------------------------------------
module optical_flow_velocity_solve (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [ofvs_pkg::FIELD_W-1:0]   sum_xx,
	input  logic signed [ofvs_pkg::FIELD_W-1:0]   sum_yy,
	input  logic signed [ofvs_pkg::FIELD_W-1:0]   sum_xy,
	input  logic signed [ofvs_pkg::FIELD_W-1:0]   sum_xt,
	input  logic signed [ofvs_pkg::FIELD_W-1:0]   sum_yt,
	input  logic                                  cfg_we,
	input  logic [ofvs_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [ofvs_pkg::CFG_DAT_W-1:0]        cfg_wdata,
	output logic                                  done,
	output logic signed [ofvs_pkg::VEL_W-1:0]     vel_x,
	output logic signed [ofvs_pkg::VEL_W-1:0]     vel_y,
	output logic                                  solved
);
	import ofvs_pkg::*;

	logic [THR_W-1:0]   det_threshold_q;
	logic [CLAMP_W-1:0] clamp_limit_q;

	logic     valid_s3;
	sums_t    sums_s3;
	logic     valid_s4, ok_s4;
	logic [PROD_W-1:0] numx_s4, numy_s4, det_s4;
	div_tag_t tagx_s4, tagy_s4;
	logic [QBITS-1:0] quo_x, quo_y;
	div_tag_t tag_x, tag_y;
	logic     vld_dly_s [QBITS+1];
	logic     ok_dly_s  [QBITS+1];
	logic     det_ok;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_threshold_q <= THR_RESET;
			clamp_limit_q   <= CLAMP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DET_THRESHOLD: det_threshold_q <= cfg_wdata[THR_W-1:0];
				CFG_CLAMP_LIMIT:   clamp_limit_q   <= cfg_wdata[CLAMP_W-1:0];
				default: ;
			endcase
		end
	end

	ofvs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.sum_xx   (sum_xx),
		.sum_yy   (sum_yy),
		.sum_xy   (sum_xy),
		.sum_xt   (sum_xt),
		.sum_yt   (sum_yt),
		.valid_s3 (valid_s3),
		.sums_s3  (sums_s3)
	);

	// stage 4: threshold test and divider setup
	assign det_ok = (sums_s3.det != '0) &&
		(sums_s3.det >= {{(PROD_W-THR_W){1'b0}}, det_threshold_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s4 <= 1'b0;
		else         valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		ok_s4       <= det_ok;
		numx_s4     <= sums_s3.numx;
		numy_s4     <= sums_s3.numy;
		det_s4      <= sums_s3.det;
		tagx_s4.neg <= sums_s3.numx_neg ^ sums_s3.det_neg;
		tagy_s4.neg <= sums_s3.numy_neg ^ sums_s3.det_neg;
		// integer part of 8 or more saturates
		tagx_s4.sat <= {{INT_BITS{1'b0}}, sums_s3.numx} >= {sums_s3.det, {INT_BITS{1'b0}}};
		tagy_s4.sat <= {{INT_BITS{1'b0}}, sums_s3.numy} >= {sums_s3.det, {INT_BITS{1'b0}}};
	end

	ofvs_divider u_div_x (
		.clk     (clk),
		.num     (numx_s4),
		.den     (det_s4),
		.tag_in  (tagx_s4),
		.quo     (quo_x),
		.tag_out (tag_x)
	);

	ofvs_divider u_div_y (
		.clk     (clk),
		.num     (numy_s4),
		.den     (det_s4),
		.tag_in  (tagy_s4),
		.quo     (quo_y),
		.tag_out (tag_y)
	);

	// valid and solved flags matched to the divider depth
	assign vld_dly_s[0] = valid_s4;
	assign ok_dly_s[0]  = ok_s4;
	for (genvar i = 0; i < QBITS; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_dly_s[i+1] <= 1'b0;
			else         vld_dly_s[i+1] <= vld_dly_s[i];
		end
		always_ff @(posedge clk) begin
			ok_dly_s[i+1] <= ok_dly_s[i];
		end
	end

	// round half away from zero, saturate, clamp, apply sign
	function automatic logic [VEL_W-1:0] finish(input logic [QBITS-1:0] q,
		input div_tag_t t, input logic [CLAMP_W-1:0] lim);
		logic [QBITS:0]   rnd;
		logic [VEL_W-1:0] mag;
		rnd = ({1'b0, q} + 1'b1) >> 1;
		mag = t.sat ? {1'b1, {(VEL_W-1){1'b0}}} : rnd[VEL_W-1:0];
		if (mag > {1'b0, lim}) mag = {1'b0, lim};
		return t.neg ? VEL_W'(~mag + 1'b1) : mag;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_dly_s[QBITS];
	end

	always_ff @(posedge clk) begin
		solved <= ok_dly_s[QBITS];
		vel_x  <= ok_dly_s[QBITS] ? finish(quo_x, tag_x, clamp_limit_q) : '0;
		vel_y  <= ok_dly_s[QBITS] ? finish(quo_y, tag_y, clamp_limit_q) : '0;
	end

endmodule
